@@ design/sbpb_pkg.sv @@
// ----------------------------------------------------------------------------
// sbpb_pkg
// shared types and constants of the spectrum bar peak ballistics core
// ----------------------------------------------------------------------------
`default_nettype none

package sbpb_pkg;

    localparam int BAR_W      = 6;
    localparam int LEVEL_W    = 16;
    localparam int GAIN_W     = 9;
    localparam int CNT_W      = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PEAK_ENABLE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ATTACK_GAIN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE_GAIN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_FRAMES    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FALL_STEP      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FAST_FALL_STEP = 3'd5;

    // register reset values
    localparam logic              RST_PEAK_ENABLE    = 1'b1;
    localparam logic [GAIN_W-1:0] RST_ATTACK_GAIN    = 9'd128;
    localparam logic [GAIN_W-1:0] RST_RELEASE_GAIN   = 9'd31;
    localparam logic [CNT_W-1:0]  RST_HOLD_FRAMES    = 8'd40;
    localparam logic [LEVEL_W-1:0] RST_FALL_STEP     = 16'd1638;
    localparam logic [LEVEL_W-1:0] RST_FAST_FALL_STEP = 16'd8192;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = {LEVEL_W{1'b1}};

    typedef struct packed {
        logic [BAR_W-1:0]   bar_index;
        logic [LEVEL_W-1:0] bin_a;
        logic [LEVEL_W-1:0] bin_b;
        logic [LEVEL_W-1:0] bin_c;
        logic [LEVEL_W-1:0] bin_d;
    } in_item_t;

    typedef struct packed {
        logic [BAR_W-1:0]   out_bar;
        logic [LEVEL_W-1:0] smoothed_level;
        logic [LEVEL_W-1:0] peak_level;
    } out_item_t;

    typedef struct packed {
        logic               peak_enable;
        logic [GAIN_W-1:0]  attack_gain;
        logic [GAIN_W-1:0]  release_gain;
        logic [CNT_W-1:0]   hold_frames;
        logic [LEVEL_W-1:0] fall_step;
        logic [LEVEL_W-1:0] fast_fall_step;
    } cfg_t;

    // per-bar state word kept in the bar memory
    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [LEVEL_W-1:0] peak;
        logic [CNT_W-1:0]   hold_cnt;
    } bar_state_t;

endpackage

`default_nettype wire

@@ design/sbpb_regs.sv @@
// ----------------------------------------------------------------------------
// sbpb_regs
// configuration register file, written through a write-enable port
// ----------------------------------------------------------------------------
`default_nettype none

module sbpb_regs (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              wr_en,
    input  wire logic [sbpb_pkg::CFG_IDX_W-1:0]    wr_index,
    input  wire logic [sbpb_pkg::CFG_DATA_W-1:0]   wr_data,
    output sbpb_pkg::cfg_t                         cfg
);

    sbpb_pkg::cfg_t cfg_reg;
    sbpb_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (wr_index)
                sbpb_pkg::REG_PEAK_ENABLE:    cfg_next.peak_enable    = wr_data[0];
                sbpb_pkg::REG_ATTACK_GAIN:
                    cfg_next.attack_gain = wr_data[sbpb_pkg::GAIN_W-1:0];
                sbpb_pkg::REG_RELEASE_GAIN:
                    cfg_next.release_gain = wr_data[sbpb_pkg::GAIN_W-1:0];
                sbpb_pkg::REG_HOLD_FRAMES:
                    cfg_next.hold_frames = wr_data[sbpb_pkg::CNT_W-1:0];
                sbpb_pkg::REG_FALL_STEP:      cfg_next.fall_step      = wr_data;
                sbpb_pkg::REG_FAST_FALL_STEP: cfg_next.fast_fall_step = wr_data;
                default: ; // unknown index, write dropped
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.peak_enable    <= sbpb_pkg::RST_PEAK_ENABLE;
            cfg_reg.attack_gain    <= sbpb_pkg::RST_ATTACK_GAIN;
            cfg_reg.release_gain   <= sbpb_pkg::RST_RELEASE_GAIN;
            cfg_reg.hold_frames    <= sbpb_pkg::RST_HOLD_FRAMES;
            cfg_reg.fall_step      <= sbpb_pkg::RST_FALL_STEP;
            cfg_reg.fast_fall_step <= sbpb_pkg::RST_FAST_FALL_STEP;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

@@ design/sbpb_store.sv @@
// ----------------------------------------------------------------------------
// sbpb_store
// per-bar state memory with registered read, valid bits and write forwarding
// ----------------------------------------------------------------------------
`default_nettype none

module sbpb_store #(
    parameter int DEPTH = 64
) (
    input  wire logic                                    aclk,
    input  wire logic                                    aresetn,
    input  wire logic                                    rd_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    input  wire logic                                    wr_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire sbpb_pkg::bar_state_t                    wr_data,
    output sbpb_pkg::bar_state_t                         rd_data
);

    sbpb_pkg::bar_state_t mem [DEPTH];
    sbpb_pkg::bar_state_t mem_rd_reg;
    sbpb_pkg::bar_state_t fwd_data_reg;
    logic [DEPTH-1:0]     vld_reg;
    logic [DEPTH-1:0]     vld_next;
    logic                 vld_rd_reg;
    logic                 fwd_reg;
    logic                 fwd_next;

    // read and write of the same entry in one cycle: pass the new word along
    assign fwd_next = rd_en && wr_en && (rd_addr == wr_addr);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            mem_rd_reg   <= mem[rd_addr];
            fwd_data_reg <= wr_data;
        end
    end

    always_comb begin
        vld_next = vld_reg;
        if (wr_en) begin
            vld_next[wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg    <= '0;
            vld_rd_reg <= 1'b0;
            fwd_reg    <= 1'b0;
        end else begin
            vld_reg <= vld_next;
            if (rd_en) begin
                vld_rd_reg <= vld_reg[rd_addr];
                fwd_reg    <= fwd_next;
            end
        end
    end

    always_comb begin
        if (fwd_reg) begin
            rd_data = fwd_data_reg;
        end else if (vld_rd_reg) begin
            rd_data = mem_rd_reg;
        end else begin
            rd_data = '0;
        end
    end

endmodule

`default_nettype wire

@@ design/sbpb_update.sv @@
// ----------------------------------------------------------------------------
// sbpb_update
// level smoothing and peak hold update for one bar
// ----------------------------------------------------------------------------
`default_nettype none

module sbpb_update (
    input  wire sbpb_pkg::cfg_t                   cfg,
    input  wire logic [sbpb_pkg::BAR_W-1:0]       bar,
    input  wire logic [sbpb_pkg::LEVEL_W-1:0]     avg,
    input  wire logic                             in_range,
    input  wire sbpb_pkg::bar_state_t             cur,
    output sbpb_pkg::bar_state_t                  nxt,
    output sbpb_pkg::out_item_t                   result
);

    localparam int LW = sbpb_pkg::LEVEL_W;
    localparam int GW = sbpb_pkg::GAIN_W;

    logic                   rising;
    logic [GW-1:0]          gain;
    logic signed [LW:0]     diff;
    logic signed [GW:0]     gain_s;
    logic signed [LW+GW+1:0] prod;
    logic signed [LW+GW-7:0] step;
    logic signed [LW+GW-6:0] nsum;
    logic [LW-1:0]          nlev;
    logic [LW-1:0]          pk;
    logic [sbpb_pkg::CNT_W-1:0] cnt;

    assign rising = avg > cur.level;
    assign gain   = rising ? cfg.attack_gain : cfg.release_gain;
    assign diff   = $signed({1'b0, avg}) - $signed({1'b0, cur.level});
    assign gain_s = $signed({1'b0, gain});
    assign prod   = diff * gain_s;
    // floor of prod / 256
    assign step   = prod[LW+GW-7+8:8];
    assign nsum   = $signed({{(GW-5){1'b0}}, cur.level}) + $signed({step[LW+GW-7], step});

    // saturate to the level range
    always_comb begin
        if (nsum[LW+GW-6]) begin
            nlev = '0;
        end else if (nsum[LW+GW-7:LW] != '0) begin
            nlev = sbpb_pkg::LEVEL_MAX;
        end else begin
            nlev = nsum[LW-1:0];
        end
    end

    always_comb begin
        pk  = cur.peak;
        cnt = cur.hold_cnt;
        if (cfg.peak_enable) begin
            if (nlev >= cur.peak) begin
                pk  = nlev;
                cnt = cfg.hold_frames;
            end else if (cur.hold_cnt != '0) begin
                cnt = cur.hold_cnt - sbpb_pkg::CNT_W'(1);
            end else begin
                pk = (cur.peak > cfg.fall_step) ? cur.peak - cfg.fall_step : '0;
            end
        end else begin
            pk = (cur.peak > cfg.fast_fall_step) ? cur.peak - cfg.fast_fall_step : '0;
        end
    end

    assign nxt.level    = nlev;
    assign nxt.peak     = pk;
    assign nxt.hold_cnt = cnt;

    assign result.out_bar        = bar;
    assign result.smoothed_level = in_range ? nlev : '0;
    assign result.peak_level     = in_range ? pk : '0;

endmodule

`default_nettype wire

@@ design/spectrum_bar_peak_ballistics_core.sv @@
// ----------------------------------------------------------------------------
// spectrum_bar_peak_ballistics_core
// per-bar level smoothing and peak hold meter for a spectrum display
// ----------------------------------------------------------------------------
// Each input beat carries a bar index and four Q0.16 bin magnitudes and gives
// exactly one result beat with the bar index, the new smoothed level and the
// new peak level. The block takes one beat per clock as long as m_ready does
// not hold back results. Accepting a beat registers the bin average and starts
// the read of the bar's state word; when stage 1 advances, the result is
// registered and the updated word written back. Back-to-back beats to the same
// bar are forwarded around the memory, so no bubble is needed. The output
// register lets a new beat enter while a result still waits on m_ready. Bar
// state clears to zero at reset through per-entry valid bits, so the block is
// ready right after reset with no clearing pass. A bar index at or above
// NUM_BARS_P leaves all state alone and returns zero levels. Configuration
// registers are written through cfg_valid/cfg_ready (always ready); an unknown
// index is ignored. Write them only while no beat is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module spectrum_bar_peak_ballistics_core #(
    parameter int NUM_BARS_P = 64
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // input beats
    input  wire logic                               s_valid,
    output wire logic                               s_ready,
    input  wire sbpb_pkg::in_item_t                 s_data,
    // result beats
    output wire logic                               m_valid,
    input  wire logic                               m_ready,
    output sbpb_pkg::out_item_t                     m_data,
    // configuration writes
    input  wire logic                               cfg_valid,
    output wire logic                               cfg_ready,
    input  wire logic [sbpb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [sbpb_pkg::CFG_DATA_W-1:0]    cfg_data
);

    // only 2^BAR_W bars can ever be addressed
    localparam int MAX_BARS = 1 << sbpb_pkg::BAR_W;
    localparam int DEPTH    = (NUM_BARS_P < MAX_BARS) ? NUM_BARS_P : MAX_BARS;
    localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    sbpb_pkg::cfg_t       cfg;
    sbpb_pkg::bar_state_t cur_state;
    sbpb_pkg::bar_state_t new_state;
    sbpb_pkg::out_item_t  result;

    // stage 1: accepted beat waiting for its state word
    logic                         s1_valid_reg;
    logic [sbpb_pkg::BAR_W-1:0]   s1_bar_reg;
    logic [sbpb_pkg::LEVEL_W-1:0] s1_avg_reg;
    logic                         s1_in_range_reg;

    // stage 2: result register
    logic                         m_valid_reg;
    sbpb_pkg::out_item_t          m_data_reg;

    logic                         s_accept;
    logic                         s1_advance;
    logic                         s1_wr_en;
    logic [sbpb_pkg::LEVEL_W+1:0] bin_sum;
    logic                         in_range;

    // config port never stalls
    assign cfg_ready = 1'b1;

    sbpb_regs u_regs (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // stage 1 moves on when the result register is empty or being drained
    assign s1_advance = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready    = !s1_valid_reg || s1_advance;
    assign s_accept   = s_valid && s_ready;
    // out of range bars never write the memory
    assign s1_wr_en   = s1_advance && s1_in_range_reg;

    // average of the four bins, truncated
    assign bin_sum = {2'b00, s_data.bin_a} + {2'b00, s_data.bin_b}
                   + {2'b00, s_data.bin_c} + {2'b00, s_data.bin_d};
    assign in_range = 32'(s_data.bar_index) < 32'(NUM_BARS_P);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_ready) begin
            s1_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_bar_reg      <= s_data.bar_index;
            s1_avg_reg      <= bin_sum[sbpb_pkg::LEVEL_W+1:2];
            s1_in_range_reg <= in_range;
        end
    end

    sbpb_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (s_accept),
        .rd_addr (s_data.bar_index[ADDR_W-1:0]),
        .wr_en   (s1_wr_en),
        .wr_addr (s1_bar_reg[ADDR_W-1:0]),
        .wr_data (new_state),
        .rd_data (cur_state)
    );

    sbpb_update u_update (
        .cfg      (cfg),
        .bar      (s1_bar_reg),
        .avg      (s1_avg_reg),
        .in_range (s1_in_range_reg),
        .cur      (cur_state),
        .nxt      (new_state),
        .result   (result)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (!m_valid_reg || m_ready) begin
            m_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_advance) begin
            m_data_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire
